// ===== rtl/core/dsa_pkg.sv =====
// ----------------------------------------------------------------------------
// dsa_pkg: shared types and constants for the descriptor slot allocator
// Slot counts, status and command codes, cell operations, payload structs.
// ----------------------------------------------------------------------------
package dsa_pkg;

  localparam int SLOTS   = 256;
  localparam int MAX_RUN = 16;
  localparam int IW      = $clog2(SLOTS);
  localparam int CW      = $clog2(SLOTS + 1);
  localparam int LW      = $clog2(MAX_RUN + 1);
  localparam int AW      = 64;
  localparam int SW      = 16;
  localparam int PW      = SW + IW;

  // command codes
  localparam logic [2:0] CMD_TAKE_NEXT  = 3'd0;
  localparam logic [2:0] CMD_TAKE_NAMED = 3'd1;
  localparam logic [2:0] CMD_TAKE_RUN   = 3'd2;
  localparam logic [2:0] CMD_FREE       = 3'd3;
  localparam logic [2:0] CMD_CLEAR      = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_CPU_BASE    = 2'd0;
  localparam logic [1:0] CFG_GPU_BASE    = 2'd1;
  localparam logic [1:0] CFG_SLOT_STRIDE = 2'd2;

  localparam logic [15:0] STRIDE_RESET = 16'd32;

  typedef enum logic [2:0] {
    ST_OK,
    ST_EXHAUSTED,
    ST_RANGE,
    ST_NOT_FREE,
    ST_NO_RUN,
    ST_IGNORED,
    ST_FULL
  } status_t;

  typedef enum logic [2:0] {
    CO_HOLD,
    CO_SEARCH_INIT,
    CO_SEARCH,
    CO_REMOVE,
    CO_POP,
    CO_ROTATE,
    CO_APPEND,
    CO_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t        op;
    logic [IW-1:0]   key;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SINIT,
    S_SEARCH,
    S_FOUND,
    S_SCAN,
    S_SCAN_END,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] slot_index;
    logic [4:0] run_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]    status;
    logic [7:0]    granted_index;
    logic [AW-1:0] cpu_address;
    logic [AW-1:0] gpu_address;
    logic          last;
  } out_item_t;

endpackage

// ===== rtl/core/dsa_cell.sv =====
// ----------------------------------------------------------------------------
// dsa_cell: one free-list entry
// Holds a slot value and an occupancy bit, plus a match flag that ripples
// down the chain during a search; shifts, rotates or loads on command.
// ----------------------------------------------------------------------------
module dsa_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  dsa_pkg::cell_ctrl_t    ctrl,
  input  logic [dsa_pkg::IW-1:0] reset_value,
  input  logic                   left_valid,
  input  logic                   left_pref,
  input  logic [dsa_pkg::IW-1:0] right_value,
  input  logic                   right_valid,
  output logic [dsa_pkg::IW-1:0] value,
  output logic                   valid,
  output logic                   pref
);

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= reset_value;
      valid <= 1'b1;
      pref  <= 1'b0;
    end else begin
      case (ctrl.op)
        dsa_pkg::CO_SEARCH_INIT: pref <= 1'b0;
        // set once this cell or any earlier one holds the key
        dsa_pkg::CO_SEARCH: pref <= left_pref | (valid && value == ctrl.key);
        // close the gap from the first match onward
        dsa_pkg::CO_REMOVE: begin
          if (pref) begin
            value <= right_value;
            valid <= right_valid;
          end
        end
        dsa_pkg::CO_POP, dsa_pkg::CO_ROTATE: begin
          value <= right_value;
          valid <= right_valid;
        end
        // first empty cell takes the appended slot
        dsa_pkg::CO_APPEND: begin
          if (!valid && left_valid) begin
            value <= ctrl.key;
            valid <= 1'b1;
          end
        end
        dsa_pkg::CO_CLEAR: valid <= 1'b0;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/dsa_chain.sv =====
// ----------------------------------------------------------------------------
// dsa_chain: the ordered free list as a row of cells
// Each cell talks only to its neighbors; the tail wraps to the head on rotate.
// ----------------------------------------------------------------------------
module dsa_chain (
  input  logic                   clk,
  input  logic                   rst,
  input  dsa_pkg::cell_ctrl_t    ctrl,
  output logic [dsa_pkg::IW-1:0] head_value,
  output logic                   head_valid,
  output logic                   tail_pref
);

  logic [dsa_pkg::IW-1:0] val  [dsa_pkg::SLOTS];
  logic                   vld  [dsa_pkg::SLOTS];
  logic                   pref [dsa_pkg::SLOTS];

  for (genvar i = 0; i < dsa_pkg::SLOTS; i++) begin : g_cell
    logic                   lv;
    logic                   lp;
    logic [dsa_pkg::IW-1:0] rv;
    logic                   rvl;

    if (i == 0) begin : g_head
      assign lv = 1'b1;
      assign lp = 1'b0;
    end else begin : g_body
      assign lv = vld[i-1];
      assign lp = pref[i-1];
    end

    if (i == dsa_pkg::SLOTS - 1) begin : g_tail
      assign rv  = val[0];
      assign rvl = (ctrl.op == dsa_pkg::CO_ROTATE) ? vld[0] : 1'b0;
    end else begin : g_mid
      assign rv  = val[i+1];
      assign rvl = vld[i+1];
    end

    dsa_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .reset_value (dsa_pkg::IW'(i)),
      .left_valid  (lv),
      .left_pref   (lp),
      .right_value (rv),
      .right_valid (rvl),
      .value       (val[i]),
      .valid       (vld[i]),
      .pref        (pref[i])
    );
  end

  assign head_value = val[0];
  assign head_valid = vld[0];
  assign tail_pref  = pref[dsa_pkg::SLOTS-1];

endmodule

// ===== rtl/core/descriptor_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// descriptor_slot_allocator: ordered free-list slot allocator
// Grants, frees and clears slot indices; reports CPU/GPU addresses per grant and per accepted free.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | in_data (cmd, slot_index, run_length)
//  out     | output    | out_valid/out_ready | out_data (status, index, addresses, last)
//  cfg     | input     | cfg_write           | cfg_index, cfg_data
//
// Take next, free and clear go from dispatch straight to the output stage.
// Take named searches the chain: the match flag ripples one cell per cycle
// along the chain. Take run rotates the whole chain once and then does one
// search-and-remove per granted slot. The list comes up full in ascending
// order after reset.
// One command is in flight at a time; a stalled output holds the block.
// ----------------------------------------------------------------------------
module descriptor_slot_allocator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dsa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dsa_pkg::out_item_t out_data,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  dsa_pkg::state_t        state, state_next;
  dsa_pkg::cell_ctrl_t    ctrl;

  logic [dsa_pkg::AW-1:0] cpu_base;
  logic [dsa_pkg::AW-1:0] gpu_base;
  logic [dsa_pkg::SW-1:0] slot_stride;

  logic [dsa_pkg::CW-1:0] count;
  logic [dsa_pkg::CW-1:0] high_water;
  logic [2:0]             cmd;
  logic [7:0]             sidx;
  logic [4:0]             rlen;
  logic [dsa_pkg::CW-1:0] step;
  logic [dsa_pkg::IW-1:0] run_start;
  logic [dsa_pkg::LW-1:0] run_len;
  logic                   run_found;
  logic [dsa_pkg::LW-1:0] run_k;

  dsa_pkg::status_t       res_status;
  logic [7:0]             res_index;
  logic [dsa_pkg::IW-1:0] res_slot;
  logic                   res_addr;
  logic                   res_last;

  logic [dsa_pkg::IW-1:0] head_value;
  logic                   head_valid;
  logic                   tail_pref;

  logic                   out_free;
  logic                   step_done;
  logic                   range_bad;
  logic                   rlen_bad;
  logic                   free_ignored;
  logic                   list_full;
  logic                   hw_full;
  logic [dsa_pkg::IW-1:0] run_key;
  logic [dsa_pkg::IW:0]   run_sum;
  logic                   run_eq;
  logic [dsa_pkg::LW-1:0] run_len_new;
  logic                   run_more;
  logic [dsa_pkg::PW-1:0] prod;

  // Status and key decode
  assign out_free     = !out_valid || out_ready;
  assign step_done    = (step == dsa_pkg::CW'(dsa_pkg::SLOTS - 1));
  assign range_bad    = (32'(sidx) >= dsa_pkg::SLOTS);
  assign rlen_bad     = (rlen == 5'd0) || (32'(rlen) > dsa_pkg::MAX_RUN);
  assign free_ignored = (32'(sidx) >= 32'(high_water));
  assign list_full    = (count >= dsa_pkg::CW'(dsa_pkg::SLOTS));
  assign hw_full      = (high_water >= dsa_pkg::CW'(dsa_pkg::SLOTS));
  assign run_key      = run_start + dsa_pkg::IW'(run_k);
  assign run_sum      = {1'b0, run_start} + (dsa_pkg::IW + 1)'(run_len);
  assign run_eq       = ({1'b0, head_value} == run_sum);
  assign run_len_new  = run_eq ? run_len + 1'b1 : dsa_pkg::LW'(1);
  assign run_more     = (cmd == dsa_pkg::CMD_TAKE_RUN) && (res_status == dsa_pkg::ST_OK)
                        && !res_last;
  assign prod         = dsa_pkg::PW'(slot_stride) * dsa_pkg::PW'(res_slot);

  dsa_chain u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .head_value (head_value),
    .head_valid (head_valid),
    .tail_pref  (tail_pref)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      dsa_pkg::S_IDLE: if (in_valid) state_next = dsa_pkg::S_DISPATCH;
      dsa_pkg::S_DISPATCH: begin
        case (cmd)
          dsa_pkg::CMD_TAKE_NEXT:  state_next = dsa_pkg::S_OUT;
          dsa_pkg::CMD_TAKE_NAMED: state_next = range_bad ? dsa_pkg::S_OUT : dsa_pkg::S_SINIT;
          dsa_pkg::CMD_TAKE_RUN:   state_next = rlen_bad ? dsa_pkg::S_OUT : dsa_pkg::S_SCAN;
          dsa_pkg::CMD_FREE:       state_next = dsa_pkg::S_OUT;
          dsa_pkg::CMD_CLEAR:      state_next = dsa_pkg::S_OUT;
          default:                 state_next = dsa_pkg::S_IDLE;
        endcase
      end
      dsa_pkg::S_SINIT:    state_next = dsa_pkg::S_SEARCH;
      dsa_pkg::S_SEARCH:   if (step_done) state_next = dsa_pkg::S_FOUND;
      dsa_pkg::S_FOUND:    state_next = dsa_pkg::S_OUT;
      dsa_pkg::S_SCAN:     if (step_done) state_next = dsa_pkg::S_SCAN_END;
      dsa_pkg::S_SCAN_END: state_next = run_found ? dsa_pkg::S_SINIT : dsa_pkg::S_OUT;
      dsa_pkg::S_OUT: begin
        if (out_free) state_next = run_more ? dsa_pkg::S_SINIT : dsa_pkg::S_IDLE;
      end
      default: state_next = dsa_pkg::S_IDLE;
    endcase
  end

  // Outputs: handshake and chain control
  always_comb begin
    in_ready = (state == dsa_pkg::S_IDLE);
    ctrl.op  = dsa_pkg::CO_HOLD;
    ctrl.key = (cmd == dsa_pkg::CMD_TAKE_RUN) ? run_key : dsa_pkg::IW'(sidx);
    case (state)
      dsa_pkg::S_DISPATCH: begin
        case (cmd)
          dsa_pkg::CMD_TAKE_NEXT: if (count != '0) ctrl.op = dsa_pkg::CO_POP;
          dsa_pkg::CMD_FREE: begin
            if (!free_ignored && !list_full) ctrl.op = dsa_pkg::CO_APPEND;
          end
          dsa_pkg::CMD_CLEAR: ctrl.op = dsa_pkg::CO_CLEAR;
          default: ;
        endcase
      end
      dsa_pkg::S_SINIT:  ctrl.op = dsa_pkg::CO_SEARCH_INIT;
      dsa_pkg::S_SEARCH: ctrl.op = dsa_pkg::CO_SEARCH;
      dsa_pkg::S_FOUND:  ctrl.op = dsa_pkg::CO_REMOVE;
      dsa_pkg::S_SCAN:   ctrl.op = dsa_pkg::CO_ROTATE;
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_base    <= '0;
      gpu_base    <= '0;
      slot_stride <= dsa_pkg::STRIDE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        dsa_pkg::CFG_CPU_BASE:    cpu_base    <= cfg_data;
        dsa_pkg::CFG_GPU_BASE:    gpu_base    <= cfg_data;
        dsa_pkg::CFG_SLOT_STRIDE: slot_stride <= cfg_data[dsa_pkg::SW-1:0];
        default: ;
      endcase
    end
  end

  // List bookkeeping and pending result
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= dsa_pkg::CW'(dsa_pkg::SLOTS);
      high_water <= '0;
      step       <= '0;
      run_found  <= 1'b0;
      run_k      <= '0;
    end else begin
      case (state)
        dsa_pkg::S_IDLE: begin
          if (in_valid) begin
            cmd  <= in_data.cmd;
            sidx <= in_data.slot_index;
            rlen <= in_data.run_length;
          end
        end
        dsa_pkg::S_DISPATCH: begin
          res_last <= 1'b1;
          res_addr <= 1'b0;
          res_slot <= '0;
          res_index <= sidx;
          case (cmd)
            dsa_pkg::CMD_TAKE_NEXT: begin
              if (count != '0) begin
                count      <= count - 1'b1;
                res_status <= dsa_pkg::ST_OK;
                res_slot   <= head_value;
                res_index  <= 8'(head_value);
                res_addr   <= 1'b1;
                if ((dsa_pkg::CW'(head_value) + 1'b1) > high_water)
                  high_water <= dsa_pkg::CW'(head_value) + 1'b1;
              end else if (hw_full) begin
                res_status <= dsa_pkg::ST_EXHAUSTED;
                res_index  <= '0;
              end else begin
                res_status <= dsa_pkg::ST_OK;
                res_slot   <= dsa_pkg::IW'(high_water);
                res_index  <= 8'(high_water);
                res_addr   <= 1'b1;
                high_water <= high_water + 1'b1;
              end
            end
            dsa_pkg::CMD_TAKE_NAMED: begin
              res_status <= dsa_pkg::ST_RANGE;
            end
            dsa_pkg::CMD_TAKE_RUN: begin
              res_status <= dsa_pkg::ST_NO_RUN;
              res_index  <= '0;
              step       <= '0;
              run_start  <= '0;
              run_len    <= '0;
              run_found  <= 1'b0;
            end
            dsa_pkg::CMD_FREE: begin
              if (free_ignored) begin
                res_status <= dsa_pkg::ST_IGNORED;
              end else if (list_full) begin
                res_status <= dsa_pkg::ST_FULL;
              end else begin
                res_status <= dsa_pkg::ST_OK;
                res_slot   <= dsa_pkg::IW'(sidx);
                res_addr   <= 1'b1;
                count      <= count + 1'b1;
              end
            end
            dsa_pkg::CMD_CLEAR: begin
              count      <= '0;
              high_water <= '0;
              res_status <= dsa_pkg::ST_OK;
              res_index  <= '0;
            end
            default: ;
          endcase
        end
        dsa_pkg::S_SINIT:  step <= '0;
        dsa_pkg::S_SEARCH: step <= step + 1'b1;
        dsa_pkg::S_FOUND: begin
          if (tail_pref) count <= count - 1'b1;
          if (cmd == dsa_pkg::CMD_TAKE_RUN) begin
            res_status <= dsa_pkg::ST_OK;
            res_slot   <= run_key;
            res_index  <= 8'(run_key);
            res_addr   <= 1'b1;
            res_last   <= (32'(run_k) + 1 == 32'(rlen));
            if ((dsa_pkg::CW'(run_key) + 1'b1) > high_water)
              high_water <= dsa_pkg::CW'(run_key) + 1'b1;
          end else if (tail_pref) begin
            res_status <= dsa_pkg::ST_OK;
            res_slot   <= dsa_pkg::IW'(sidx);
            res_addr   <= 1'b1;
            if ((dsa_pkg::CW'(sidx) + 1'b1) > high_water)
              high_water <= dsa_pkg::CW'(sidx) + 1'b1;
          end else begin
            res_status <= dsa_pkg::ST_NOT_FREE;
          end
        end
        // walk the list past the head once, tracking the current ascending run
        dsa_pkg::S_SCAN: begin
          step <= step + 1'b1;
          if (!run_found && head_valid) begin
            if (!run_eq) run_start <= head_value;
            run_len <= run_len_new;
            if (32'(run_len_new) == 32'(rlen)) run_found <= 1'b1;
          end
        end
        dsa_pkg::S_SCAN_END: run_k <= '0;
        dsa_pkg::S_OUT: begin
          if (out_free && run_more) run_k <= run_k + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == dsa_pkg::S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == dsa_pkg::S_OUT && out_free) begin
      out_data.status        <= res_status;
      out_data.granted_index <= res_index;
      out_data.cpu_address   <= res_addr ? cpu_base + dsa_pkg::AW'(prod) : '0;
      out_data.gpu_address   <= res_addr ? gpu_base + dsa_pkg::AW'(prod) : '0;
      out_data.last          <= res_last;
    end
  end

endmodule
